@@ rtl/kms_pkg.sv @@
// kms_pkg: shared types and constants of the keyboard matrix scanner
// no dependencies; imported by kms_poll and keyboard_matrix_scanner_unit
`timescale 1ns / 1ps

package kms_pkg;

  localparam int unsigned NumRows   = 8;
  localparam int unsigned RowWidth  = 8;
  localparam int unsigned CodeWidth = 6;

  // shift key positions: row 1 column 7 and row 6 column 4
  localparam logic [2:0] ShiftRowA = 3'd1;
  localparam logic [2:0] ShiftColA = 3'd7;
  localparam logic [2:0] ShiftRowB = 3'd6;
  localparam logic [2:0] ShiftColB = 3'd4;
  localparam logic [RowWidth-1:0] ShiftMaskA = 8'h7f;
  localparam logic [RowWidth-1:0] ShiftMaskB = 8'hef;

  // column encoding groups
  localparam logic [RowWidth-1:0] ColGroup4 = 8'hf0;
  localparam logic [RowWidth-1:0] ColGroup2 = 8'hcc;
  localparam logic [RowWidth-1:0] ColGroup1 = 8'haa;

  localparam logic [RowWidth-1:0] RowQuiet = 8'hff;

  typedef logic [NumRows-1:0][RowWidth-1:0] kms_matrix_t;

  typedef struct packed {
    logic [RowWidth-1:0]  idle_read;
    logic [RowWidth-1:0]  all_rows_read;
    kms_matrix_t          row_read;
    logic [CodeWidth-1:0] query_code;
  } kms_item_t;

  typedef struct packed {
    logic                 new_key;
    logic [CodeWidth-1:0] scan_code;
    logic                 with_shift;
    logic                 query_pressed;
    logic                 shift_held;
  } kms_result_t;

endpackage

@@ rtl/kms_poll.sv @@
// kms_poll: combinational evaluation of one poll against the held matrix
// depends on kms_pkg
`timescale 1ns / 1ps

module kms_poll (
  input  kms_pkg::kms_item_t   item_i,
  input  kms_pkg::kms_matrix_t held_i,
  output kms_pkg::kms_matrix_t held_o,
  output kms_pkg::kms_result_t result_o
);
  import kms_pkg::*;

  function automatic logic [2:0] encode_columns(input logic [RowWidth-1:0] fresh);
    logic [2:0] c;
    c[2] = |(fresh & ColGroup4);
    c[1] = |(fresh & ColGroup2);
    c[0] = |(fresh & ColGroup1);
    return c;
  endfunction

  kms_matrix_t          base;
  kms_matrix_t          next_rows;
  logic                 found;
  logic [CodeWidth-1:0] code;
  logic                 shift_now;
  logic                 poll_taken;
  logic                 any_key;
  logic [RowWidth-1:0]  fresh;

  assign poll_taken = (item_i.idle_read == RowQuiet);
  assign any_key    = (item_i.all_rows_read != RowQuiet);

  always_comb begin
    // shift keys count as already held so they never show as new
    base = held_i;
    base[ShiftRowB] = held_i[ShiftRowB] & ShiftMaskB;
    base[ShiftRowA] = held_i[ShiftRowA] & ShiftMaskA;
    found = 1'b0;
    code  = '0;
    fresh = '0;
    for (int i = 0; i < NumRows; i++) begin
      fresh = ~item_i.row_read[i] & base[i];
      if (fresh != '0) begin
        found = 1'b1;
        code  = {3'(i), encode_columns(fresh)};
      end
    end
  end

  always_comb begin
    if (!poll_taken) begin
      next_rows = held_i;
    end else if (any_key) begin
      next_rows = item_i.row_read;
    end else begin
      next_rows = {NumRows{RowQuiet}};
    end
  end

  assign shift_now = ~next_rows[ShiftRowB][ShiftColB] | ~next_rows[ShiftRowA][ShiftColA];

  assign held_o                 = next_rows;
  assign result_o.new_key       = poll_taken & any_key & found;
  assign result_o.scan_code     = (poll_taken & any_key) ? code : '0;
  assign result_o.with_shift    = poll_taken & any_key & found & shift_now;
  assign result_o.query_pressed =
      ~next_rows[item_i.query_code[5:3]][item_i.query_code[2:0]];
  assign result_o.shift_held    = shift_now;

endmodule

@@ rtl/keyboard_matrix_scanner_unit.sv @@
// keyboard_matrix_scanner_unit: 8x8 active-low key matrix poll evaluator
// path: each request is registered in the request stage, then its result
// in the result stage
// throughput: one request per cycle when results are not stalled, set by
// the single-pass poll logic between the request and result registers
// reset: asynchronous active low; matrix all released, both stages emptied
`timescale 1ns / 1ps

module keyboard_matrix_scanner_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] idle_read_i,
  input  logic [7:0] all_rows_read_i,
  input  logic [7:0] row0_read_i,
  input  logic [7:0] row1_read_i,
  input  logic [7:0] row2_read_i,
  input  logic [7:0] row3_read_i,
  input  logic [7:0] row4_read_i,
  input  logic [7:0] row5_read_i,
  input  logic [7:0] row6_read_i,
  input  logic [7:0] row7_read_i,
  input  logic [5:0] query_code_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       new_key_o,
  output logic [5:0] scan_code_o,
  output logic       with_shift_o,
  output logic       query_pressed_o,
  output logic       shift_held_o
);
  // depends on kms_pkg and kms_poll
  import kms_pkg::*;

  // request register stage
  logic        req_valid_q;
  kms_item_t   req_q;
  kms_item_t   req_d;

  // held key matrix, low bit means the key is down
  kms_matrix_t held_q;
  kms_matrix_t held_d;

  // result register stage
  logic        res_valid_q;
  kms_result_t res_q;
  kms_result_t res_d;

  logic        in_fire;
  logic        res_load;

  // the result stage takes a new poll whenever it is empty or being drained
  assign res_load   = req_valid_q & (~res_valid_q | out_ready_i);
  // request stage refills in the same cycle it hands over
  assign in_ready_o = ~req_valid_q | res_load;
  assign in_fire    = in_valid_i & in_ready_o;

  always_comb begin
    req_d.idle_read     = idle_read_i;
    req_d.all_rows_read = all_rows_read_i;
    req_d.row_read      = {row7_read_i, row6_read_i, row5_read_i, row4_read_i,
                           row3_read_i, row2_read_i, row1_read_i, row0_read_i};
    req_d.query_code    = query_code_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_fire) begin
      req_valid_q <= 1'b1;
    end else if (res_load) begin
      req_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= req_d;
    end
  end

  // poll evaluation against the stored matrix
  kms_poll u_poll (
    .item_i   (req_q),
    .held_i   (held_q),
    .held_o   (held_d),
    .result_o (res_d)
  );

  // matrix advances only when its poll moves into the result stage,
  // so polls update it strictly in request order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= {NumRows{RowQuiet}};
    end else if (res_load) begin
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = res_valid_q;
  assign new_key_o       = res_q.new_key;
  assign scan_code_o     = res_q.scan_code;
  assign with_shift_o    = res_q.with_shift;
  assign query_pressed_o = res_q.query_pressed;
  assign shift_held_o    = res_q.shift_held;

`ifndef NO_ASSERTIONS
  // a stalled result is never overwritten by the next poll
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !out_ready_i) |-> !res_load)
    else $error("result stage overwritten while stalled");

  // shift with a new key implies a new key and shift still held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.with_shift) |-> (res_q.new_key && res_q.shift_held))
    else $error("with_shift without new key or shift held");

  // the matrix only changes when a poll is handed to the result stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(res_load) |-> $stable(held_q))
    else $error("held matrix changed without a poll");
`endif

endmodule

@@ test/keyboard_matrix_scanner_unit_test.sv @@
// keyboard_matrix_scanner_unit_test: self-checking bench for the key matrix poll unit
// holds its own model of the held-key matrix; depends on kms_pkg and the unit itself
`timescale 1ns / 1ps

module keyboard_matrix_scanner_unit_test;

  import kms_pkg::*;

  // tracks the held-key matrix and the poll results it implies
  class key_poll_tracker;
    logic [RowWidth-1:0] held [NumRows];
    kms_result_t         due_polls [$];
    int                  failures;

    function new();
      foreach (held[i]) held[i] = RowQuiet;
      failures = 0;
    endfunction

    function int pending();
      return due_polls.size();
    endfunction

    function logic shift_down();
      return !held[ShiftRowA][ShiftColA] || !held[ShiftRowB][ShiftColB];
    endfunction

    // column code: weight 4 for the upper nibble, 2 and 1 for the other groups
    function logic [2:0] column_code(logic [RowWidth-1:0] fresh);
      return {|(fresh & ColGroup4), |(fresh & ColGroup2), |(fresh & ColGroup1)};
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void note_poll(kms_item_t req);
      kms_result_t         want;
      logic [RowWidth-1:0] fresh;
      want = '0;
      if (req.idle_read == RowQuiet) begin
        if (req.all_rows_read != RowQuiet) begin
          // shift keys never count as a fresh press
          held[ShiftRowA] &= ShiftMaskA;
          held[ShiftRowB] &= ShiftMaskB;
          for (int i = 0; i < NumRows; i++) begin
            fresh = ~req.row_read[i] & held[i];
            held[i] = req.row_read[i];
            if (fresh != '0) begin
              want.new_key   = 1'b1;
              want.scan_code = {i[2:0], column_code(fresh)};
            end
          end
          if (want.new_key) want.with_shift = shift_down();
        end else begin
          foreach (held[i]) held[i] = RowQuiet;
        end
      end
      want.query_pressed = !held[req.query_code[5:3]][req.query_code[2:0]];
      want.shift_held    = shift_down();
      due_polls.push_back(want);
    endfunction

    function void check_poll(kms_result_t got);
      kms_result_t want;
      if (due_polls.size() == 0) begin
        report($sformatf("result with no request outstanding: new_key=%0d scan_code=%0d",
                         got.new_key, got.scan_code));
        return;
      end
      want = due_polls.pop_front();
      if (got.new_key !== want.new_key || got.scan_code !== want.scan_code ||
          got.with_shift !== want.with_shift || got.query_pressed !== want.query_pressed ||
          got.shift_held !== want.shift_held) begin
        report($sformatf({"poll mismatch: expected new_key=%0d scan_code=%0d with_shift=%0d ",
                          "query_pressed=%0d shift_held=%0d, got %0d %0d %0d %0d %0d"},
                         want.new_key, want.scan_code, want.with_shift, want.query_pressed,
                         want.shift_held, got.new_key, got.scan_code, got.with_shift,
                         got.query_pressed, got.shift_held));
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              out_ready = 1'b0;
  kms_item_t         poll_req = '1;
  logic              in_ready_o;
  logic              out_valid_o;
  logic              new_key_o;
  logic [5:0]        scan_code_o;
  logic              with_shift_o;
  logic              query_pressed_o;
  logic              shift_held_o;
  key_poll_tracker   tracker;
  logic              tx_calm = 1'b0;
  logic              rx_calm = 1'b0;
  int                rx_stall = 0;

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  keyboard_matrix_scanner_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .idle_read_i    (poll_req.idle_read),
    .all_rows_read_i(poll_req.all_rows_read),
    .row0_read_i    (poll_req.row_read[0]),
    .row1_read_i    (poll_req.row_read[1]),
    .row2_read_i    (poll_req.row_read[2]),
    .row3_read_i    (poll_req.row_read[3]),
    .row4_read_i    (poll_req.row_read[4]),
    .row5_read_i    (poll_req.row_read[5]),
    .row6_read_i    (poll_req.row_read[6]),
    .row7_read_i    (poll_req.row_read[7]),
    .query_code_i   (poll_req.query_code),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .new_key_o      (new_key_o),
    .scan_code_o    (scan_code_o),
    .with_shift_o   (with_shift_o),
    .query_pressed_o(query_pressed_o),
    .shift_held_o   (shift_held_o)
  );

  // idle length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic kms_item_t make_poll(logic [7:0] idle, logic [7:0] all,
                                          kms_matrix_t rows, logic [5:0] query);
    kms_item_t req;
    req.idle_read     = idle;
    req.all_rows_read = all;
    req.row_read      = rows;
    req.query_code    = query;
    return req;
  endfunction

  // present one request, hold it until taken, then idle for a random while or not at all;
  // valid stays high across back-to-back requests
  task automatic send_poll(input kms_item_t req);
    int gap;
    in_valid <= 1'b1;
    poll_req <= req;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_poll(req);
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // result side: random back-pressure with calm stretches now and then
  always @(posedge clk_i) begin
    if ($urandom_range(0, 149) == 0) rx_calm <= ~rx_calm;
    if (rx_stall > 0) begin
      out_ready <= 1'b0;
      rx_stall  <= rx_stall - 1;
    end else begin
      out_ready <= 1'b1;
      if (!rx_calm && $urandom_range(0, 3) == 0) rx_stall <= pick_gap();
    end
  end

  // result monitor: values seen at the edge, before any update from it
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      tracker.check_poll({new_key_o, scan_code_o, with_shift_o, query_pressed_o,
                          shift_held_o});
    end
  end

  initial begin
    kms_matrix_t m;
    kms_matrix_t kb;
    kms_item_t   req;
    logic [2:0]  rr;
    logic [2:0]  cc;
    int          r;

    tracker = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: quiet poll, then single presses at both corners of the matrix
    m = '1;
    send_poll(make_poll(RowQuiet, RowQuiet, m, 6'd0));
    m[0] = 8'hfe;
    send_poll(make_poll(RowQuiet, 8'hfe, m, 6'd0));
    // same key still down: no fresh press
    send_poll(make_poll(RowQuiet, 8'hfe, m, 6'd63));
    m[7] = 8'h7f;
    send_poll(make_poll(RowQuiet, 8'h7e, m, 6'd63));
    // noisy column lines with nothing driven: poll ignored
    send_poll(make_poll(8'h00, 8'h00, '0, 6'd0));
    send_poll(make_poll(8'hfe, 8'h00, '0, 6'd7));
    send_poll(make_poll(8'h7f, 8'h00, '0, 6'd56));
    // nothing down with all rows driven: everything released, row reads ignored
    send_poll(make_poll(RowQuiet, RowQuiet, '0, 6'd56));
    // shift keys on their own never make a fresh key
    m = '1;
    m[1] = 8'h7f;
    send_poll(make_poll(RowQuiet, 8'h7f, m, 6'd15));
    m = '1;
    m[6] = 8'hef;
    send_poll(make_poll(RowQuiet, 8'hef, m, 6'd52));
    // shift held together with a fresh key
    m[3] = 8'hfb;
    send_poll(make_poll(RowQuiet, 8'heb, m, 6'd26));
    // two fresh presses in one row merge into one column code
    m = '1;
    send_poll(make_poll(RowQuiet, RowQuiet, m, 6'd23));
    m[2] = 8'h7e;
    send_poll(make_poll(RowQuiet, 8'h7e, m, 6'd23));
    // fresh presses in two rows: the later row wins
    m = '1;
    m[0] = 8'hdf;
    m[5] = 8'hf7;
    send_poll(make_poll(RowQuiet, 8'hd7, m, 6'd43));
    // every key at once
    m = '0;
    send_poll(make_poll(RowQuiet, 8'h00, m, 6'd63));
    // rows say pressed but the all-rows read is quiet: released
    send_poll(make_poll(RowQuiet, RowQuiet, m, 6'd12));
    // all-rows read shows a key, row reads show none
    m = '1;
    send_poll(make_poll(RowQuiet, 8'h00, m, 6'd33));
    m[4] = 8'h55;
    send_poll(make_poll(RowQuiet, 8'h55, m, 6'd32));
    send_poll(make_poll(RowQuiet, 8'h55, m, 6'd33));

    // random part: mostly a plausible keyboard with keys coming and going
    kb = '1;
    for (int n = 0; n < 800; n++) begin
      if (n == 400) begin
        // hold off until every result is back
        in_valid <= 1'b0;
        do @(posedge clk_i); while (tracker.pending() != 0);
      end
      if ($urandom_range(0, 39) == 0) tx_calm = ~tx_calm;
      r = $urandom_range(0, 99);
      req.query_code = 6'($urandom_range(0, 63));
      if (r < 8) begin
        // line noise on the idle read
        req.idle_read     = 8'($urandom_range(0, 254));
        req.all_rows_read = 8'($urandom);
        req.row_read      = {$urandom, $urandom};
      end else if (r < 13) begin
        // arbitrary reads, consistent or not
        req.idle_read     = RowQuiet;
        req.all_rows_read = 8'($urandom);
        req.row_read      = {$urandom, $urandom};
      end else if (r < 21) begin
        // every key let go
        kb                = '1;
        req.idle_read     = RowQuiet;
        req.all_rows_read = RowQuiet;
        req.row_read      = (r < 17) ? kb : kms_matrix_t'({$urandom, $urandom});
      end else begin
        for (int t = $urandom_range(1, 3); t > 0; t--) begin
          rr = 3'($urandom_range(0, 7));
          cc = 3'($urandom_range(0, 7));
          kb[rr][cc] = ~kb[rr][cc];
        end
        if ($urandom_range(0, 6) == 0) kb[ShiftRowA][ShiftColA] = ~kb[ShiftRowA][ShiftColA];
        if ($urandom_range(0, 6) == 0) kb[ShiftRowB][ShiftColB] = ~kb[ShiftRowB][ShiftColB];
        req.idle_read     = RowQuiet;
        req.row_read      = kb;
        req.all_rows_read = RowQuiet;
        for (int i = 0; i < NumRows; i++) req.all_rows_read &= kb[i];
        if ($urandom_range(0, 4) == 0) begin
          req.query_code = ($urandom_range(0, 1) == 0) ? {ShiftRowA, ShiftColA}
                                                      : {ShiftRowB, ShiftColB};
        end
      end
      send_poll(req);
    end
    in_valid <= 1'b0;

    // drain, then a short settling time for anything stray
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/kms_pkg.sv
rtl/kms_poll.sv
rtl/keyboard_matrix_scanner_unit.sv
test/keyboard_matrix_scanner_unit_test.sv
